// ===== sv/utf8v_pkg.sv =====
// ----------------------------------------------------------------------------
// utf8v_pkg
// Shared types and byte-class constants for the UTF-8 validator.
// ----------------------------------------------------------------------------
package utf8v_pkg;

  localparam int unsigned OUT_W = 32;

  // Byte class boundaries
  localparam logic [7:0] ZERO_BYTE  = 8'h00;
  localparam logic [7:0] NEWLINE    = 8'h0A;
  localparam logic [7:0] SINGLE_TOP = 8'h7F;
  localparam logic [7:0] CONT_MIN   = 8'h80;
  localparam logic [7:0] CONT_MAX   = 8'hBF;
  localparam logic [7:0] LEAD2_MIN  = 8'hC2;
  localparam logic [7:0] LEAD2_MAX  = 8'hDF;
  localparam logic [7:0] LEAD3_MIN  = 8'hE0;
  localparam logic [7:0] LEAD3_MAX  = 8'hEF;
  localparam logic [7:0] LEAD4_MIN  = 8'hF0;
  localparam logic [7:0] LEAD4_MAX  = 8'hF4;

  typedef logic [1:0] pend_t;

  localparam pend_t PEND_NONE  = 2'd0;
  localparam pend_t PEND_ONE   = 2'd1;
  localparam pend_t PEND_TWO   = 2'd2;
  localparam pend_t PEND_THREE = 2'd3;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic             still_valid;
    logic             first_error;
    logic [OUT_W-1:0] err_line;
    logic [OUT_W-1:0] err_column;
    logic [OUT_W-1:0] err_offset;
    logic             end_of_text;
  } out_item_t;

  // Decoder verdict for one byte
  typedef struct packed {
    logic  is_zero;
    logic  is_newline;
    logic  bad;
    pend_t pend_dec;
  } dec_t;

endpackage

// ===== sv/utf8_validator_with_position.sv =====
// ----------------------------------------------------------------------------
// utf8_validator_with_position
// UTF-8 structure checker that reports the line, column and offset of the
// first invalid byte of each text.
// ----------------------------------------------------------------------------
//
//   channel   signals                          carries
//   -------   ------------------------------   -------------------------------
//   input     in_valid  in_ready  in_data      one text byte and its last flag
//   result    out_valid out_ready out_data     verdict and first error spot
//
// Flow: one transfer per clock in both directions while out_ready is high;
//   each byte passes through the input register and then the result
//   register, which its result transfers from. The per-byte decode and
//   counter update sit between the input register and the result register.
// Reset: rst_n low clears both stages and returns the validator to the start
//   of a text (line 1, column 1, offset 0, no error).
// Stalls: out_ready low holds the result register; the input register still
//   takes a transfer while it is empty, so one item waits on each side.
//
module utf8_validator_with_position
  import utf8v_pkg::*;
#(
  parameter int unsigned COUNT_WIDTH = 32
)
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  // --------------------------------------------------------------------------
  // Handshake: advance the result stage when it is empty or being drained,
  // and refill the input stage whenever it is empty or moving on.
  // --------------------------------------------------------------------------
  logic      in_valid_r;
  in_item_t  in_item_r;
  logic      out_valid_r;
  out_item_t out_item_r, out_item_nxt;
  logic      adv;
  logic      step;

  assign adv      = !out_valid_r || out_ready;
  assign step     = in_valid_r && adv;
  assign in_ready = !in_valid_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  // Payload: load on transfer only
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_item_r <= in_data;
    end
  end

  // --------------------------------------------------------------------------
  // Decode state: continuation bytes due and the sticky error flag.
  // --------------------------------------------------------------------------
  pend_t pend_r, pend_nxt;
  logic  err_r, err_nxt;
  dec_t  dec;

  utf8v_decode u_decode (
    .text_byte (in_item_r.text_byte),
    .pend      (pend_r),
    .dec       (dec)
  );

  logic [COUNT_WIDTH-1:0] cur_line, cur_col, cur_off;
  logic                   ends;

  // A zero byte ends the text regardless of the last flag
  assign ends = dec.is_zero || in_item_r.last_byte;

  utf8v_pos #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_pos (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (step),
    .ends       (ends),
    .is_newline (dec.is_newline),
    .line_num   (cur_line),
    .col_num    (cur_col),
    .offset     (cur_off)
  );

  // --------------------------------------------------------------------------
  // First error: a bad byte, or a text that closes with a sequence cut short.
  // Both take the position of the current byte, before its counter update.
  // --------------------------------------------------------------------------
  logic latch;
  logic err_after;

  always_comb begin
    if (dec.is_zero) begin
      latch = !err_r && (pend_r != PEND_NONE);
    end else begin
      latch = !err_r && (dec.bad || (in_item_r.last_byte && dec.pend_dec != PEND_NONE));
    end
  end

  assign err_after = err_r || latch;

  always_comb begin
    pend_nxt = pend_r;
    err_nxt  = err_r;
    if (step) begin
      if (ends) begin
        pend_nxt = PEND_NONE;
        err_nxt  = 1'b0;
      end else begin
        // drop pending work once an error is on record
        pend_nxt = err_after ? PEND_NONE : dec.pend_dec;
        err_nxt  = err_after;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= PEND_NONE;
      err_r  <= 1'b0;
    end else begin
      pend_r <= pend_nxt;
      err_r  <= err_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Saved error position, kept at the 32-bit result width.
  // --------------------------------------------------------------------------
  logic [OUT_W-1:0] line_lo, col_lo, off_lo;

  generate
    if (COUNT_WIDTH >= OUT_W) begin : g_trunc
      assign line_lo = cur_line[OUT_W-1:0];
      assign col_lo  = cur_col[OUT_W-1:0];
      assign off_lo  = cur_off[OUT_W-1:0];
    end else begin : g_ext
      assign line_lo = {{(OUT_W-COUNT_WIDTH){1'b0}}, cur_line};
      assign col_lo  = {{(OUT_W-COUNT_WIDTH){1'b0}}, cur_col};
      assign off_lo  = {{(OUT_W-COUNT_WIDTH){1'b0}}, cur_off};
    end
  endgenerate

  logic [OUT_W-1:0] sv_line_r, sv_line_nxt;
  logic [OUT_W-1:0] sv_col_r, sv_col_nxt;
  logic [OUT_W-1:0] sv_off_r, sv_off_nxt;
  logic [OUT_W-1:0] rep_line, rep_col, rep_off;

  assign rep_line = latch ? line_lo : sv_line_r;
  assign rep_col  = latch ? col_lo  : sv_col_r;
  assign rep_off  = latch ? off_lo  : sv_off_r;

  always_comb begin
    sv_line_nxt = sv_line_r;
    sv_col_nxt  = sv_col_r;
    sv_off_nxt  = sv_off_r;
    if (step) begin
      if (ends) begin
        sv_line_nxt = '0;
        sv_col_nxt  = '0;
        sv_off_nxt  = '0;
      end else begin
        sv_line_nxt = rep_line;
        sv_col_nxt  = rep_col;
        sv_off_nxt  = rep_off;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sv_line_r <= '0;
      sv_col_r  <= '0;
      sv_off_r  <= '0;
    end else begin
      sv_line_r <= sv_line_nxt;
      sv_col_r  <= sv_col_nxt;
      sv_off_r  <= sv_off_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Result register: shows the state before any end-of-text clearing.
  // --------------------------------------------------------------------------
  always_comb begin
    out_item_nxt.still_valid = !err_after;
    out_item_nxt.first_error = latch;
    out_item_nxt.err_line    = rep_line;
    out_item_nxt.err_column  = rep_col;
    out_item_nxt.err_offset  = rep_off;
    out_item_nxt.end_of_text = ends;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_item_r <= out_item_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_item_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_err_no_pending: assert property (@(posedge clk) disable iff (!rst_n)
    err_r |-> (pend_r == PEND_NONE))
    else $error("pending count held after an error");

  a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (step && ends) |=> (!err_r && pend_r == PEND_NONE && sv_off_r == '0))
    else $error("state not cleared after end of text");

  a_first_not_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.first_error) |-> !out_data.still_valid)
    else $error("first error reported on a valid text");

  a_valid_no_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.still_valid) |->
      (out_data.err_line == '0 && out_data.err_column == '0 && out_data.err_offset == '0))
    else $error("error position reported with no error");

endmodule

// ===== sv/utf8v_decode.sv =====
// ----------------------------------------------------------------------------
// utf8v_decode
// Classifies one byte against the number of continuation bytes still due.
// ----------------------------------------------------------------------------
module utf8v_decode
  import utf8v_pkg::*;
(
  input  logic [7:0] text_byte,
  input  pend_t      pend,
  output dec_t       dec
);

  always_comb begin
    dec            = '0;
    dec.is_zero    = (text_byte == ZERO_BYTE);
    dec.is_newline = (text_byte == NEWLINE);
    dec.pend_dec   = pend;
    if (pend == PEND_NONE) begin
      if (text_byte inside {[ZERO_BYTE:SINGLE_TOP]}) begin
        dec.pend_dec = PEND_NONE;
      end else if (text_byte inside {[LEAD2_MIN:LEAD2_MAX]}) begin
        dec.pend_dec = PEND_ONE;
      end else if (text_byte inside {[LEAD3_MIN:LEAD3_MAX]}) begin
        dec.pend_dec = PEND_TWO;
      end else if (text_byte inside {[LEAD4_MIN:LEAD4_MAX]}) begin
        dec.pend_dec = PEND_THREE;
      end else begin
        dec.bad = 1'b1;
      end
    end else begin
      // continuation expected
      if (text_byte inside {[CONT_MIN:CONT_MAX]}) begin
        dec.pend_dec = pend - PEND_ONE;
      end else begin
        dec.bad      = 1'b1;
        dec.pend_dec = PEND_NONE;
      end
    end
  end

endmodule

// ===== sv/utf8v_pos.sv =====
// ----------------------------------------------------------------------------
// utf8v_pos
// Saturating line, column and byte offset counters of the current byte.
// ----------------------------------------------------------------------------
module utf8v_pos
  import utf8v_pkg::*;
#(
  parameter int unsigned COUNT_WIDTH = 32
)
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   step,
  input  logic                   ends,
  input  logic                   is_newline,
  output logic [COUNT_WIDTH-1:0] line_num,
  output logic [COUNT_WIDTH-1:0] col_num,
  output logic [COUNT_WIDTH-1:0] offset
);

  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;
  localparam logic [COUNT_WIDTH-1:0] CNT_ONE = COUNT_WIDTH'(1);

  logic [COUNT_WIDTH-1:0] line_r, line_nxt;
  logic [COUNT_WIDTH-1:0] col_r, col_nxt;
  logic [COUNT_WIDTH-1:0] off_r, off_nxt;

  always_comb begin
    line_nxt = line_r;
    col_nxt  = col_r;
    off_nxt  = off_r;
    if (step) begin
      if (ends) begin
        line_nxt = CNT_ONE;
        col_nxt  = CNT_ONE;
        off_nxt  = '0;
      end else begin
        if (is_newline) begin
          line_nxt = (line_r == CNT_MAX) ? line_r : line_r + CNT_ONE;
          col_nxt  = CNT_ONE;
        end else begin
          col_nxt  = (col_r == CNT_MAX) ? col_r : col_r + CNT_ONE;
        end
        off_nxt = (off_r == CNT_MAX) ? off_r : off_r + CNT_ONE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_r <= CNT_ONE;
      col_r  <= CNT_ONE;
      off_r  <= '0;
    end else begin
      line_r <= line_nxt;
      col_r  <= col_nxt;
      off_r  <= off_nxt;
    end
  end

  assign line_num = line_r;
  assign col_num  = col_r;
  assign offset   = off_r;

endmodule

// ===== tb/tb_utf8_validator_with_position.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_utf8_validator_with_position
// Self-checking bench for the UTF-8 validator with error position tracking.
// Texts are streamed byte by byte over the input channel. A predictor in the
// bench keeps its own copy of the decode state, and every result transfer is
// compared against it field by field. Directed texts come first, then random
// texts under random gaps, receiver stalls and a long back-pressure hold.
// ----------------------------------------------------------------------------
module tb_utf8_validator_with_position;
  import utf8v_pkg::*;

  localparam int CW         = 32;       // counter width of the block
  localparam int TIMEOUT_NS = 400_000;  // far above the slowest correct run

  // Kinds of random text the generator can build
  typedef enum {
    TEXT_WELL_FORMED,
    TEXT_CORRUPTED,
    TEXT_CUT_SHORT,
    TEXT_NOISE
  } text_kind_t;

  typedef logic [7:0] byte_q_t[$];

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_data;

  utf8_validator_with_position u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // --------------------------------------------------------------------------
  // Predictor state: a private copy of what the block should hold
  // --------------------------------------------------------------------------
  pend_t          pend_left;
  logic [CW-1:0]  line_cnt;
  logic [CW-1:0]  col_cnt;
  logic [CW-1:0]  offset_cnt;
  logic           error_latched;
  logic [CW-1:0]  err_line_q;
  logic [CW-1:0]  err_col_q;
  logic [CW-1:0]  err_offset_q;

  // Verdicts predicted for accepted bytes, oldest first
  out_item_t verdict_q[$];

  // Idle knobs shared by the sender and the receiver
  int gap_max;     // longest sender gap between bursts, 0 = no gaps
  int burst_max;   // longest sender burst
  int stall_max;   // longest receiver stall, 0 = always ready
  int ready_max;   // longest receiver ready run
  int hold_left;   // long hold-off requested from the receiver
  int burst_left;

  // Run statistics
  int mismatch_count;
  int bytes_sent;
  int results_checked;
  int texts_closed;
  int first_errors;

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------
  function automatic void predictor_clear();
    pend_left     = PEND_NONE;
    line_cnt      = 1;
    col_cnt       = 1;
    offset_cnt    = '0;
    error_latched = 1'b0;
    err_line_q    = '0;
    err_col_q     = '0;
    err_offset_q  = '0;
  endfunction

  function automatic logic [CW-1:0] bump_sat(input logic [CW-1:0] v);
    return (&v) ? v : v + 1'b1;
  endfunction

  // Latch the current position as the first error; 1 if this call latched it
  function automatic logic latch_error();
    if (error_latched) return 1'b0;
    error_latched = 1'b1;
    err_line_q    = line_cnt;
    err_col_q     = col_cnt;
    err_offset_q  = offset_cnt;
    return 1'b1;
  endfunction

  function automatic out_item_t utf8_predict(input in_item_t item);
    out_item_t  r;
    logic       bad;
    logic       ends;
    logic       first;
    logic [7:0] b;
    b     = item.text_byte;
    first = 1'b0;
    bad   = 1'b0;
    if (b == ZERO_BYTE) begin
      // A zero byte closes the text; a sequence left open is an error here
      ends = 1'b1;
      if (pend_left != PEND_NONE) first |= latch_error();
    end else begin
      ends = item.last_byte;
      if (pend_left == PEND_NONE) begin
        if (b <= SINGLE_TOP) begin
          // plain single-byte character
        end else if (b < LEAD2_MIN) begin
          bad = 1'b1;
        end else if (b <= LEAD2_MAX) begin
          pend_left = PEND_ONE;
        end else if (b <= LEAD3_MAX) begin
          pend_left = PEND_TWO;
        end else if (b <= LEAD4_MAX) begin
          pend_left = PEND_THREE;
        end else begin
          bad = 1'b1;
        end
      end else if (b >= CONT_MIN && b <= CONT_MAX) begin
        pend_left = pend_t'(pend_left - 1'b1);
      end else begin
        bad       = 1'b1;
        pend_left = PEND_NONE;
      end
      if (bad) first |= latch_error();
      // Text ends on this byte with a sequence still open
      if (item.last_byte && pend_left != PEND_NONE) first |= latch_error();
      if (bad || error_latched) pend_left = PEND_NONE;
      if (b == NEWLINE) begin
        line_cnt = bump_sat(line_cnt);
        col_cnt  = 1;
      end else begin
        col_cnt = bump_sat(col_cnt);
      end
      offset_cnt = bump_sat(offset_cnt);
    end
    r.still_valid = !error_latched;
    r.first_error = first;
    r.err_line    = err_line_q[OUT_W-1:0];
    r.err_column  = err_col_q[OUT_W-1:0];
    r.err_offset  = err_offset_q[OUT_W-1:0];
    r.end_of_text = ends;
    if (ends) predictor_clear();
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Reporting and checking
  // --------------------------------------------------------------------------
  task automatic report_mismatch(input string msg);
    $display("[%0t] MISMATCH: %s", $realtime, msg);
    mismatch_count++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want)
      report_mismatch($sformatf("result %0d %s got %0d want %0d",
                                results_checked, name, got, want));
  endtask

  // Compare every result transfer with the oldest prediction
  always @(posedge clk) begin : result_check
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (verdict_q.size() == 0) begin
        report_mismatch("result transfer with no prediction waiting");
      end else begin
        want = verdict_q.pop_front();
        check_field("still_valid", 32'(out_data.still_valid), 32'(want.still_valid));
        check_field("first_error", 32'(out_data.first_error), 32'(want.first_error));
        check_field("err_line",    out_data.err_line,    want.err_line);
        check_field("err_column",  out_data.err_column,  want.err_column);
        check_field("err_offset",  out_data.err_offset,  want.err_offset);
        check_field("end_of_text", 32'(out_data.end_of_text), 32'(want.end_of_text));
        if (want.end_of_text) texts_closed++;
        if (want.first_error) first_errors++;
      end
      results_checked++;
    end
  end

  // --------------------------------------------------------------------------
  // Clock, timeout and receiver
  // --------------------------------------------------------------------------
  initial begin : clock_gen
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("timeout with %0d results still expected", verdict_q.size());
    $display("end of test: mismatches");
    $finish;
  end

  // Receiver: alternate ready runs and stall runs of random length, and
  // honor a long hold-off whenever one is requested.
  initial begin : result_sink
    int run;
    run = 0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_ready = 1'b0;
        hold_left--;
      end else if (run > 0) begin
        run--;
      end else if (out_ready && stall_max > 0) begin
        out_ready = 1'b0;
        run       = $urandom_range(0, stall_max - 1);
      end else begin
        out_ready = 1'b1;
        run       = $urandom_range(0, ready_max - 1);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sender
  // --------------------------------------------------------------------------
  task automatic set_idling(input int gaps, input int bursts, input int stalls,
                            input int readys);
    gap_max   = gaps;
    burst_max = bursts;
    stall_max = stalls;
    ready_max = readys;
  endtask

  // Offer one byte; insert a random gap at burst boundaries, hold the
  // payload until the transfer, then record the prediction.
  task automatic send_byte(input logic [7:0] b, input logic lst);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, burst_max);
      gap        = (gap_max > 0) ? $urandom_range(0, gap_max) : 0;
      if (gap > 0) begin
        @(negedge clk);
        in_valid = 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    in_valid = 1'b1;
    in_data  = in_item_t'{text_byte: b, last_byte: lst};
    do @(posedge clk); while (!in_ready);
    verdict_q.insert(verdict_q.size(), utf8_predict(in_data));
    bytes_sent++;
  endtask

  // Send a text; flag its final byte as last when asked
  task automatic send_text_bytes(input byte_q_t txt, input logic mark_last);
    foreach (txt[i])
      send_byte(txt[i], mark_last && (i == txt.size() - 1));
  endtask

  // Drop valid and wait until every predicted result has arrived
  task automatic drain_results();
    @(negedge clk);
    in_valid   = 1'b0;
    burst_left = 0;
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic logic [7:0] random_bad_byte();
    case ($urandom_range(0, 2))
      0:       return 8'($urandom_range(CONT_MIN, LEAD2_MIN - 1));
      1:       return 8'($urandom_range(LEAD4_MAX + 1, 8'hFF));
      default: return 8'($urandom_range(1, 255));
    endcase
  endfunction

  // Build one random text of the given kind and send it, ended either by
  // the last flag or by a zero byte.
  task automatic send_random_text(input text_kind_t kind);
    byte_q_t    body;
    int         nchars;
    int         nconts;
    int         pos;
    logic [7:0] lead;
    nchars = ($urandom_range(0, 15) == 0) ? $urandom_range(20, 60)
                                          : $urandom_range(1, 12);
    for (int k = 0; k < nchars; k++) begin
      if (kind == TEXT_NOISE) begin
        body.insert(body.size(), 8'($urandom_range(1, 255)));
        continue;
      end
      case ($urandom_range(0, 9))
        5, 6: begin
          lead   = 8'($urandom_range(LEAD2_MIN, LEAD2_MAX));
          nconts = 1;
        end
        7, 8: begin
          lead   = 8'($urandom_range(LEAD3_MIN, LEAD3_MAX));
          nconts = 2;
        end
        9: begin
          lead   = 8'($urandom_range(LEAD4_MIN, LEAD4_MAX));
          nconts = 3;
        end
        default: begin
          lead   = ($urandom_range(0, 5) == 0) ? NEWLINE
                                               : 8'($urandom_range(1, 127));
          nconts = 0;
        end
      endcase
      body.insert(body.size(), lead);
      repeat (nconts) body.insert(body.size(), 8'($urandom_range(CONT_MIN, CONT_MAX)));
    end
    if (kind == TEXT_CUT_SHORT) begin
      // Open a multi-byte sequence and stop before it completes
      nconts = $urandom_range(0, 2);
      case (nconts)
        0:       body.insert(body.size(), 8'($urandom_range(LEAD2_MIN, LEAD4_MAX)));
        1:       body.insert(body.size(), 8'($urandom_range(LEAD3_MIN, LEAD4_MAX)));
        default: body.insert(body.size(), 8'($urandom_range(LEAD4_MIN, LEAD4_MAX)));
      endcase
      repeat (nconts) body.insert(body.size(), 8'($urandom_range(CONT_MIN, CONT_MAX)));
    end
    if (kind == TEXT_CORRUPTED) begin
      pos       = $urandom_range(0, body.size() - 1);
      body[pos] = random_bad_byte();
    end
    if ($urandom_range(0, 3) == 0) begin
      send_text_bytes(body, 1'b0);
      send_byte(ZERO_BYTE, 1'($urandom_range(0, 1)));
    end else begin
      send_text_bytes(body, 1'b1);
    end
  endtask

  task automatic random_texts(input int byte_goal, input int noise_pct);
    int stop_at;
    int pick;
    stop_at = bytes_sent + byte_goal;
    while (bytes_sent < stop_at) begin
      pick = $urandom_range(0, 99);
      if (pick < noise_pct)           send_random_text(TEXT_NOISE);
      else if (pick < noise_pct + 15) send_random_text(TEXT_CORRUPTED);
      else if (pick < noise_pct + 27) send_random_text(TEXT_CUT_SHORT);
      else                            send_random_text(TEXT_WELL_FORMED);
    end
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  // Valid texts: ASCII edge, newline, two- and four-byte leads, zero terminator
  task automatic test_well_formed();
    send_text_bytes('{8'h41, NEWLINE, SINGLE_TOP}, 1'b1);
    send_text_bytes('{LEAD2_MIN, CONT_MIN, LEAD4_MAX, 8'h8F, CONT_MAX, CONT_MAX,
                      ZERO_BYTE}, 1'b0);
    drain_results();
  endtask

  // Invalid leads, bad continuation, errors after the first one
  task automatic test_invalid_bytes();
    // error at the start of the second line, then a second unreported error
    send_text_bytes('{NEWLINE, CONT_MIN, 8'hFF}, 1'b1);
    // ASCII where a continuation belongs
    send_text_bytes('{LEAD3_MIN, 8'h41, ZERO_BYTE}, 1'b0);
    send_byte(8'(LEAD2_MIN - 1), 1'b1);
    send_byte(8'(LEAD4_MAX + 1), 1'b1);
    // zero byte with the last flag acts as a plain zero
    send_byte(ZERO_BYTE, 1'b1);
    drain_results();
  endtask

  // Sequences cut short by the last flag and by a zero byte
  task automatic test_cut_short();
    send_text_bytes('{LEAD2_MAX, CONT_MAX, LEAD3_MIN, 8'hA0}, 1'b1);
    send_text_bytes('{LEAD4_MIN, CONT_MIN, ZERO_BYTE}, 1'b0);
    drain_results();
  endtask

  task automatic test_random_mixed();
    set_idling(6, 8, 4, 8);
    random_texts(600, 10);
    drain_results();
  endtask

  // Hold the receiver off for a long stretch while the sender keeps going,
  // so both stages fill and in_ready drops.
  task automatic test_backpressure();
    set_idling(0, 64, 2, 6);
    hold_left = 300;
    random_texts(40, 0);
    drain_results();
  endtask

  // Back-to-back transfers with neither side idling
  task automatic test_streaming();
    set_idling(0, 64, 0, 64);
    random_texts(400, 5);
    drain_results();
  endtask

  task automatic test_noise();
    set_idling(3, 4, 6, 3);
    random_texts(300, 70);
    drain_results();
  endtask

  task automatic test_heavy_idling();
    set_idling(12, 3, 8, 2);
    random_texts(400, 15);
    drain_results();
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin : main_sequence
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_data        = '0;
    out_ready      = 1'b0;
    hold_left      = 0;
    burst_left     = 0;
    mismatch_count = 0;
    bytes_sent     = 0;
    results_checked = 0;
    texts_closed   = 0;
    first_errors   = 0;
    set_idling(2, 6, 3, 6);
    predictor_clear();

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_well_formed();
    test_invalid_bytes();
    test_cut_short();
    test_random_mixed();
    test_backpressure();
    test_streaming();
    test_noise();
    test_heavy_idling();

    drain_results();
    repeat (8) @(posedge clk);

    $display("checked %0d results for %0d bytes across %0d texts",
             results_checked, bytes_sent, texts_closed);
    $display("%0d texts latched an error position, %0d field mismatches",
             first_errors, mismatch_count);
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ===== utf8_validator_with_position.f =====
sv/utf8v_pkg.sv
sv/utf8v_decode.sv
sv/utf8v_pos.sv
sv/utf8_validator_with_position.sv
tb/tb_utf8_validator_with_position.sv
